// ===== rtl/core/brhp_pkg.sv =====
// brhp_pkg: shared widths, verdict codes and the queue entry type of the
// byte range header parser. No dependencies.
`default_nettype none

package brhp_pkg;

  localparam int HDR_W     = 8;
  localparam int LEN_W     = 32;
  localparam int VERDICT_W = 2;

  localparam logic [VERDICT_W-1:0] VERDICT_IGNORE = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_OK     = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_UNSAT  = 2'd2;

  // what the front found when the header ended
  typedef enum logic [1:0] {
    CLS_NONE      = 2'd0,
    CLS_SUFFIX    = 2'd1,
    CLS_RANGE     = 2'd2,
    CLS_LATE_FAIL = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [LEN_W-1:0] start_value;
    logic [LEN_W-1:0] end_value;
    logic             end_written;
    logic [LEN_W-1:0] file_length;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/brhp_if.sv =====
// brhp_hdr_if and brhp_rsp_if: valid/ready channels for header bytes and
// range results. Depends on brhp_pkg.
`default_nettype none

interface brhp_hdr_if;
  import brhp_pkg::*;
  logic             valid;
  logic             ready;
  logic [HDR_W-1:0] header_byte;
  logic [LEN_W-1:0] file_length;

  modport source (output valid, output header_byte, output file_length, input ready);
  modport sink   (input valid, input header_byte, input file_length, output ready);
endinterface

interface brhp_rsp_if;
  import brhp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [LEN_W-1:0]     range_first;
  logic [LEN_W-1:0]     range_last;

  modport source (output valid, output verdict, output range_first, output range_last,
                  input ready);
  modport sink   (input valid, input verdict, input range_first, input range_last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brhp_front.sv =====
// brhp_front: per-byte range header scanner; classifies the header and pushes
// one request per terminator. Depends on brhp_pkg and brhp_hdr_if.
`default_nettype none

module brhp_front (
  input  wire logic      clk,
  input  wire logic      rst,
  brhp_hdr_if.sink       hdr,
  input  wire logic      full,
  output logic           push,
  output brhp_pkg::entry_t push_entry
);
  import brhp_pkg::*;

  typedef enum logic [13:0] {
    PH_LEAD    = 14'b00000000000001,
    PH_MATCH_Y = 14'b00000000000010,
    PH_MATCH_T = 14'b00000000000100,
    PH_MATCH_E = 14'b00000000001000,
    PH_MATCH_S = 14'b00000000010000,
    PH_MATCH_EQ= 14'b00000000100000,
    PH_POSTEQ  = 14'b00000001000000,
    PH_SUF0    = 14'b00000010000000,
    PH_SUFD    = 14'b00000100000000,
    PH_STARTD  = 14'b00001000000000,
    PH_DASH    = 14'b00010000000000,
    PH_ENDD    = 14'b00100000000000,
    PH_TRAIL   = 14'b01000000000000,
    PH_SKIP    = 14'b10000000000000
  } phase_t;

  localparam logic [HDR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [HDR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [HDR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [HDR_W-1:0] CH_DASH  = 8'h2d;
  localparam logic [HDR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [HDR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [HDR_W-1:0] CH_B     = 8'h62;
  localparam logic [HDR_W-1:0] CH_Y     = 8'h79;
  localparam logic [HDR_W-1:0] CH_T     = 8'h74;
  localparam logic [HDR_W-1:0] CH_E     = 8'h65;
  localparam logic [HDR_W-1:0] CH_S     = 8'h73;
  localparam logic [HDR_W-1:0] CH_EQ    = 8'h3d;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] start_value, start_value_next;
  logic [LEN_W-1:0] end_value, end_value_next;
  logic             end_written, end_written_next;
  logic             suffix_form, suffix_form_next;
  logic             late_fail, late_fail_next;

  logic             accept;
  logic             is_term;
  logic             is_blank;
  logic             is_dig;
  logic [3:0]       digit;
  logic [LEN_W-1:0] acc;
  logic [LEN_W+3:0] scaled;
  logic             ovf;
  logic             past_dash;
  logic             suffix_done;
  logic [HDR_W-1:0] c;

  assign hdr.ready = !full;
  assign accept    = hdr.valid && hdr.ready;
  assign c         = hdr.header_byte;
  assign is_term   = (c == CH_NUL);
  assign is_blank  = (c == CH_SPACE) || (c == CH_TAB);
  assign is_dig    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit     = c[3:0];

  // shared shift-add for one decimal digit
  assign acc    = (phase == PH_STARTD) ? start_value : end_value;
  assign scaled = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, digit};
  assign ovf    = |scaled[LEN_W+3:LEN_W];

  assign past_dash   = (phase == PH_DASH) || (phase == PH_ENDD) ||
                       ((phase == PH_TRAIL) && !suffix_form);
  assign suffix_done = (phase == PH_SUFD) || ((phase == PH_TRAIL) && suffix_form);

  always_comb begin
    phase_next       = phase;
    start_value_next = start_value;
    end_value_next   = end_value;
    end_written_next = end_written;
    suffix_form_next = suffix_form;
    late_fail_next   = late_fail;
    if (accept) begin
      if (is_term) begin
        phase_next       = PH_LEAD;
        start_value_next = '0;
        end_value_next   = '0;
        end_written_next = 1'b0;
        suffix_form_next = 1'b0;
        late_fail_next   = 1'b0;
      end else begin
        unique case (phase)
          PH_LEAD: begin
            if (!is_blank) begin
              if (c == CH_B) begin
                phase_next = PH_MATCH_Y;
              end else begin
                phase_next     = PH_SKIP;
                late_fail_next = past_dash;
              end
            end
          end
          PH_MATCH_Y: begin
            if (c == CH_Y) begin
              phase_next = PH_MATCH_T;
            end else begin
              phase_next     = PH_SKIP;
              late_fail_next = past_dash;
            end
          end
          PH_MATCH_T: begin
            if (c == CH_T) begin
              phase_next = PH_MATCH_E;
            end else begin
              phase_next     = PH_SKIP;
              late_fail_next = past_dash;
            end
          end
          PH_MATCH_E: begin
            if (c == CH_E) begin
              phase_next = PH_MATCH_S;
            end else begin
              phase_next     = PH_SKIP;
              late_fail_next = past_dash;
            end
          end
          PH_MATCH_S: begin
            if (c == CH_S) begin
              phase_next = PH_MATCH_EQ;
            end else begin
              phase_next     = PH_SKIP;
              late_fail_next = past_dash;
            end
          end
          PH_MATCH_EQ: begin
            if (c == CH_EQ) begin
              phase_next = PH_POSTEQ;
            end else begin
              phase_next     = PH_SKIP;
              late_fail_next = past_dash;
            end
          end
          PH_POSTEQ: begin
            if (!is_blank) begin
              if (c == CH_DASH) begin
                suffix_form_next = 1'b1;
                phase_next       = PH_SUF0;
              end else if (is_dig) begin
                start_value_next = {28'd0, digit};
                phase_next       = PH_STARTD;
              end else begin
                phase_next     = PH_SKIP;
                late_fail_next = past_dash;
              end
            end
          end
          PH_SUF0: begin
            if (is_dig) begin
              end_value_next = {28'd0, digit};
              phase_next     = PH_SUFD;
            end else begin
              phase_next     = PH_SKIP;
              late_fail_next = past_dash;
            end
          end
          PH_SUFD, PH_ENDD: begin
            if (is_dig && !ovf) begin
              end_value_next = scaled[LEN_W-1:0];
            end else if (is_blank) begin
              phase_next = PH_TRAIL;
            end else begin
              phase_next     = PH_SKIP;
              late_fail_next = past_dash;
            end
          end
          PH_STARTD: begin
            if (is_dig && !ovf) begin
              start_value_next = scaled[LEN_W-1:0];
            end else if (c == CH_DASH) begin
              phase_next = PH_DASH;
            end else begin
              phase_next     = PH_SKIP;
              late_fail_next = past_dash;
            end
          end
          PH_DASH: begin
            if (is_dig) begin
              end_value_next   = {28'd0, digit};
              end_written_next = 1'b1;
              phase_next       = PH_ENDD;
            end else if (is_blank) begin
              phase_next = PH_TRAIL;
            end else begin
              phase_next     = PH_SKIP;
              late_fail_next = past_dash;
            end
          end
          PH_TRAIL: begin
            if (!is_blank) begin
              phase_next     = PH_SKIP;
              late_fail_next = past_dash;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      start_value <= '0;
      end_value   <= '0;
      end_written <= 1'b0;
      suffix_form <= 1'b0;
      late_fail   <= 1'b0;
    end else begin
      phase       <= phase_next;
      start_value <= start_value_next;
      end_value   <= end_value_next;
      end_written <= end_written_next;
      suffix_form <= suffix_form_next;
      late_fail   <= late_fail_next;
    end
  end

  assign push = accept && is_term;

  always_comb begin
    push_entry.start_value = start_value;
    push_entry.end_value   = end_value;
    push_entry.end_written = end_written;
    push_entry.file_length = hdr.file_length;
    if (suffix_done) begin
      push_entry.cls = CLS_SUFFIX;
    end else if (past_dash) begin
      push_entry.cls = CLS_RANGE;
    end else if ((phase == PH_SKIP) && late_fail) begin
      push_entry.cls = CLS_LATE_FAIL;
    end else begin
      push_entry.cls = CLS_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brhp_queue.sv =====
// brhp_queue: small request queue between front and back.
// Depends on brhp_pkg.
`default_nettype none

module brhp_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire brhp_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output brhp_pkg::entry_t      head,
  output logic                  empty
);
  import brhp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         slots [DEPTH];
  logic [AW-1:0]  wr_ptr, wr_ptr_next;
  logic [AW-1:0]  rd_ptr, rd_ptr_next;
  logic [CW-1:0]  count, count_next;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brhp_back.sv =====
// brhp_back: turns a queued request into the verdict and clamped range and
// holds it in the output register. Depends on brhp_pkg and brhp_rsp_if.
`default_nettype none

module brhp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             empty,
  input  wire brhp_pkg::entry_t head,
  output logic                  pop,
  brhp_rsp_if.source            result
);
  import brhp_pkg::*;

  logic                 rsp_valid;
  logic [VERDICT_W-1:0] verdict, verdict_next;
  logic [LEN_W-1:0]     range_first, range_first_next;
  logic [LEN_W-1:0]     range_last, range_last_next;

  logic [LEN_W-1:0] len;
  logic             len_zero;
  logic             end_ge_len;
  logic             start_ge_len;
  logic             end_lt_start;
  logic [LEN_W-1:0] suffix_first;
  logic [LEN_W-1:0] len_last;

  assign len          = head.file_length;
  assign len_zero     = (len == '0);
  assign end_ge_len   = (head.end_value >= len);
  assign start_ge_len = (head.start_value >= len);
  assign end_lt_start = (head.end_value < head.start_value);
  assign suffix_first = len - head.end_value;
  assign len_last     = len - 1'b1;

  always_comb begin
    verdict_next     = VERDICT_IGNORE;
    range_first_next = '0;
    range_last_next  = '0;
    unique case (head.cls)
      CLS_SUFFIX: begin
        if ((head.end_value == '0) || len_zero) begin
          verdict_next = VERDICT_UNSAT;
        end else begin
          verdict_next     = VERDICT_OK;
          range_first_next = end_ge_len ? '0 : suffix_first;
          range_last_next  = len_last;
        end
      end
      CLS_RANGE: begin
        if (len_zero || start_ge_len) begin
          verdict_next = VERDICT_UNSAT;
        end else if (head.end_written && end_lt_start) begin
          verdict_next = VERDICT_IGNORE;
        end else begin
          verdict_next     = VERDICT_OK;
          range_first_next = head.start_value;
          range_last_next  = (head.end_written && !end_ge_len) ? head.end_value : len_last;
        end
      end
      CLS_LATE_FAIL: begin
        verdict_next = len_zero ? VERDICT_UNSAT : VERDICT_IGNORE;
      end
      default: begin
        verdict_next = VERDICT_IGNORE;
      end
    endcase
  end

  assign pop = !empty && (!rsp_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (result.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict     <= verdict_next;
      range_first <= range_first_next;
      range_last  <= range_last_next;
    end
  end

  assign result.valid       = rsp_valid;
  assign result.verdict     = verdict;
  assign result.range_first = range_first;
  assign result.range_last  = range_last;

endmodule

`default_nettype wire

// ===== rtl/core/byte_range_header_parser_core.sv =====
// byte_range_header_parser_core: takes one header byte per cycle while hdr.ready
// is high; the request of a terminating byte is queued, then registered as a result.
// hdr.ready drops only when the request queue is full, which the output register's
// backpressure decides.
// Synchronous reset returns the scanner to the leading blank phase and
// empties the queue and the output register.
`default_nettype none

module byte_range_header_parser_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  brhp_hdr_if.sink    hdr,
  brhp_rsp_if.source  result
);
  import brhp_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  entry_t head;
  logic   empty;

  brhp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hdr        (hdr),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  brhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  brhp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== rtl/core/brhp_checker.sv =====
// brhp_checker: port-level checks on the result channel of the parser,
// bound to byte_range_header_parser_core. Depends on brhp_pkg.
`default_nettype none

module brhp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              valid,
  input wire logic              ready,
  input wire logic [1:0]        verdict,
  input wire logic [31:0]       range_first,
  input wire logic [31:0]       range_last
);
  import brhp_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(verdict) && $stable(range_first) &&
                        $stable(range_last))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    valid |-> (verdict == VERDICT_IGNORE) || (verdict == VERDICT_OK) ||
              (verdict == VERDICT_UNSAT))
    else $error("bad verdict code");

  a_order: assert property (@(posedge clk) disable iff (rst)
    valid && (verdict == VERDICT_OK) |-> range_first <= range_last)
    else $error("range first past last");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    valid && (verdict != VERDICT_OK) |-> (range_first == '0) && (range_last == '0))
    else $error("range set without satisfiable verdict");

endmodule

bind byte_range_header_parser_core brhp_checker u_brhp_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .verdict     (result.verdict),
  .range_first (result.range_first),
  .range_last  (result.range_last)
);

`default_nettype wire
